### src/gtc_pkg.sv
// Shared types and codes for the glyph tag cache.
// Used by gtc_table and glyph_tag_cache_aging_replacement_top; depends on nothing.
`default_nettype none

package gtc_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int FACES_DEF   = 11;
  localparam int SLOT_W      = 6;

  localparam logic [20:0] BMP_MAX       = 21'h00FFFF;
  localparam logic [7:0]  CLOCK_RESTART = 8'd128;
  localparam logic [7:0]  CLOCK_LAST    = 8'hFF;

  // Request types.
  localparam logic [1:0] REQ_GLYPH = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_DONE  = 2'd2;

  // Entry states.
  localparam logic [1:0] ES_EMPTY   = 2'd0;
  localparam logic [1:0] ES_LOADING = 2'd1;
  localparam logic [1:0] ES_LOADED  = 2'd2;
  localparam logic [1:0] ES_FAILED  = 2'd3;

  // Result codes.
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_NON_BMP  = 3'd1;
  localparam logic [2:0] ST_BAD_FACE = 3'd2;
  localparam logic [2:0] ST_BUSY     = 3'd3;
  localparam logic [2:0] ST_RELOAD   = 3'd4;
  localparam logic [2:0] ST_MISS     = 3'd5;
  localparam logic [2:0] ST_CAPACITY = 3'd6;
  localparam logic [2:0] ST_ACK      = 3'd7;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [20:0] codepoint;
    logic [3:0]  face;
    logic [7:0]  pin_bits;
    logic [7:0]  clear_mask;
    logic [5:0]  done_slot;
    logic        load_ok;
    logic        presenting;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       ready_res;
    logic [5:0] slot;
  } out_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [15:0] cp;
    logic [3:0]  face;
    logic [7:0]  age;
    logic [7:0]  pins;
  } entry_t;

endpackage

`default_nettype wire

### src/gtc_table.sv
// Entry table of the glyph tag cache: one synchronous RAM, one read and one write port.
// Per-entry valid bits make never-written entries read as all zero. Uses gtc_pkg.
`default_nettype none

module gtc_table #(
  parameter int ENTRIES = gtc_pkg::ENTRIES_DEF,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   wr_en,
  input  wire [IDX_W-1:0]       wr_addr,
  input  wire gtc_pkg::entry_t  wr_data,
  input  wire [IDX_W-1:0]       rd_addr,
  output gtc_pkg::entry_t       rd_data
);

  gtc_pkg::entry_t ram_r [ENTRIES];
  gtc_pkg::entry_t q_r;
  logic [ENTRIES-1:0] vld_r;
  logic qv_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram_r[wr_addr] <= wr_data;
    end
    q_r <= ram_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      qv_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = qv_r ? q_r : '0;

endmodule

`default_nettype wire

### src/glyph_tag_cache_aging_replacement_top.sv
// Glyph tag cache with aging replacement and pinning: sequencer over the entry table.
// Depends on gtc_pkg and gtc_table.
//
// Usage: drive in_data and raise start; the item is taken at a clock edge where busy
// is low. Every item gives exactly one result, shown on out_data for one cycle with
// out_valid high; the receiver cannot hold it off. There is no configuration port.
// Bad face, non-BMP code points, request type 3 and stale completion reports answer
// in the cycle after acceptance and leave busy low. A glyph request scans the whole
// table through the single RAM read port, one entry per cycle; when the aging clock
// wraps, a second pass halves every age before the entry is written. A clear request
// sweeps the table once; a matching completion report takes a read and a write.
// One item is worked on at a time; busy stays high until its result is out.
// A synchronous reset (rst_n low) empties the table through its valid bits, zeroes
// the aging clock and drops any outstanding load; no clearing pass is needed.
`default_nettype none

module glyph_tag_cache_aging_replacement_top #(
  parameter int ENTRIES = gtc_pkg::ENTRIES_DEF,
  parameter int FACES   = gtc_pkg::FACES_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  wire gtc_pkg::in_t in_data,
  output logic             out_valid,
  output gtc_pkg::out_t    out_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int CW    = ((IDX_W > gtc_pkg::SLOT_W) ? IDX_W : gtc_pkg::SLOT_W) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_HALVE  = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;
  localparam logic [2:0] S_CLR    = 3'd5;
  localparam logic [2:0] S_DRD    = 3'd6;
  localparam logic [2:0] S_DWR    = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0] p_idx_r, p_idx_nxt;
  logic [7:0]       age_clk_r, age_clk_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_slot_r, pend_slot_nxt;
  logic             out_valid_r, out_valid_nxt;
  gtc_pkg::out_t    out_data_r, out_data_nxt;

  gtc_pkg::in_t     req_r, req_nxt;
  logic [IDX_W-1:0] tgt_r, tgt_nxt;
  gtc_pkg::entry_t  wdata_r, wdata_nxt;
  gtc_pkg::out_t    res_r, res_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] found_idx_r, found_idx_nxt;
  logic [1:0]       found_st_r, found_st_nxt;
  logic [7:0]       found_pins_r, found_pins_nxt;
  logic             emp_r, emp_nxt;
  logic [IDX_W-1:0] emp_idx_r, emp_idx_nxt;
  logic             vic_r, vic_nxt;
  logic [IDX_W-1:0] vic_idx_r, vic_idx_nxt;
  logic [7:0]       vic_age_r, vic_age_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  gtc_pkg::entry_t  wr_data;
  logic [IDX_W-1:0] rd_addr;
  gtc_pkg::entry_t  e;

  logic             sweep;
  logic             rd_en;
  logic             last;
  logic [7:0]       tick_age;
  logic             wrap;
  logic [CW-1:0]    done_ext;
  logic             done_match;
  logic             ld_block;
  logic [IDX_W-1:0] sel_idx;

  function automatic logic [gtc_pkg::SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [CW-1:0] x;
    x = CW'(idx);
    return x[gtc_pkg::SLOT_W-1:0];
  endfunction

  gtc_table #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (e)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sweep   = (state_r == S_SCAN) || (state_r == S_HALVE) || (state_r == S_CLR);
  assign rd_en   = sweep && (cnt_r < CNT_W'(ENTRIES));
  assign rd_addr = (state_r == S_DRD) ? tgt_r : cnt_r[IDX_W-1:0];
  assign last    = p_vld_r && (p_idx_r == IDX_W'(ENTRIES - 1));

  // The aging clock wraps from 255 to 128; a wrap halves every stored age first.
  assign wrap     = (age_clk_r == gtc_pkg::CLOCK_LAST);
  assign tick_age = wrap ? gtc_pkg::CLOCK_RESTART : age_clk_r + 8'd1;

  assign done_ext   = CW'(in_data.done_slot);
  assign done_match = pend_r && (done_ext == CW'(pend_slot_r)) && (done_ext < CW'(ENTRIES));
  assign ld_block   = pend_r || req_r.presenting;
  assign sel_idx    = emp_r ? emp_idx_r : vic_idx_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = rd_en ? cnt_r + CNT_W'(1) : cnt_r;
    p_vld_nxt      = rd_en;
    p_idx_nxt      = cnt_r[IDX_W-1:0];
    age_clk_nxt    = age_clk_r;
    pend_nxt       = pend_r;
    pend_slot_nxt  = pend_slot_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    req_nxt        = req_r;
    tgt_nxt        = tgt_r;
    wdata_nxt      = wdata_r;
    res_nxt        = res_r;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    found_st_nxt   = found_st_r;
    found_pins_nxt = found_pins_r;
    emp_nxt        = emp_r;
    emp_idx_nxt    = emp_idx_r;
    vic_nxt        = vic_r;
    vic_idx_nxt    = vic_idx_r;
    vic_age_nxt    = vic_age_r;
    wr_en          = 1'b0;
    wr_addr        = p_idx_r;
    wr_data        = e;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_data;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          emp_nxt   = 1'b0;
          vic_nxt   = 1'b0;
          unique case (in_data.req_type)
            gtc_pkg::REQ_GLYPH: begin
              priority if ({1'b0, in_data.face} >= 5'(FACES)) begin
                out_valid_nxt          = 1'b1;
                out_data_nxt.status    = gtc_pkg::ST_BAD_FACE;
                out_data_nxt.ready_res = 1'b0;
                out_data_nxt.slot      = '0;
              end else if (in_data.codepoint > gtc_pkg::BMP_MAX) begin
                out_valid_nxt          = 1'b1;
                out_data_nxt.status    = gtc_pkg::ST_NON_BMP;
                out_data_nxt.ready_res = 1'b1;
                out_data_nxt.slot      = '0;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            gtc_pkg::REQ_CLEAR: begin
              state_nxt = S_CLR;
            end
            gtc_pkg::REQ_DONE: begin
              if (done_match) begin
                tgt_nxt   = pend_slot_r;
                state_nxt = S_DRD;
              end else begin
                out_valid_nxt          = 1'b1;
                out_data_nxt.status    = gtc_pkg::ST_ACK;
                out_data_nxt.ready_res = 1'b0;
                out_data_nxt.slot      = in_data.done_slot;
              end
            end
            default: begin
              out_valid_nxt          = 1'b1;
              out_data_nxt.status    = gtc_pkg::ST_ACK;
              out_data_nxt.ready_res = 1'b0;
              out_data_nxt.slot      = '0;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (p_vld_r) begin
          if (!found_r && (e.st != gtc_pkg::ES_EMPTY) &&
              (e.cp == req_r.codepoint[15:0]) && (e.face == req_r.face)) begin
            found_nxt      = 1'b1;
            found_idx_nxt  = p_idx_r;
            found_st_nxt   = e.st;
            found_pins_nxt = e.pins;
          end
          if (!emp_r && (e.st == gtc_pkg::ES_EMPTY)) begin
            emp_nxt     = 1'b1;
            emp_idx_nxt = p_idx_r;
          end
          // Strict compare keeps the lowest index among equal ages.
          if ((e.pins == 8'd0) && (!vic_r || (e.age < vic_age_r))) begin
            vic_nxt     = 1'b1;
            vic_idx_nxt = p_idx_r;
            vic_age_nxt = e.age;
          end
          if (last) begin
            state_nxt = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        cnt_nxt = '0;
        priority if (found_r) begin
          tgt_nxt       = found_idx_r;
          age_clk_nxt   = tick_age;
          wdata_nxt.st   = found_st_r;
          wdata_nxt.cp   = req_r.codepoint[15:0];
          wdata_nxt.face = req_r.face;
          wdata_nxt.age  = tick_age;
          wdata_nxt.pins = found_pins_r | req_r.pin_bits;
          res_nxt.slot   = slot_of(found_idx_r);
          priority if ((found_st_r == gtc_pkg::ES_LOADED) ||
                       (found_st_r == gtc_pkg::ES_FAILED)) begin
            res_nxt.status    = gtc_pkg::ST_HIT;
            res_nxt.ready_res = 1'b1;
          end else if (ld_block) begin
            res_nxt.status    = gtc_pkg::ST_BUSY;
            res_nxt.ready_res = 1'b0;
          end else begin
            res_nxt.status    = gtc_pkg::ST_RELOAD;
            res_nxt.ready_res = 1'b0;
            pend_nxt          = 1'b1;
            pend_slot_nxt     = found_idx_r;
          end
          state_nxt = wrap ? S_HALVE : S_WRITE;
        end else if (ld_block || !(emp_r || vic_r)) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = ld_block ? gtc_pkg::ST_BUSY : gtc_pkg::ST_CAPACITY;
          out_data_nxt.ready_res = 1'b0;
          out_data_nxt.slot      = '0;
          state_nxt              = S_IDLE;
        end else begin
          tgt_nxt           = sel_idx;
          age_clk_nxt       = tick_age;
          wdata_nxt.st      = gtc_pkg::ES_LOADING;
          wdata_nxt.cp      = req_r.codepoint[15:0];
          wdata_nxt.face    = req_r.face;
          wdata_nxt.age     = tick_age;
          wdata_nxt.pins    = req_r.pin_bits;
          res_nxt.status    = gtc_pkg::ST_MISS;
          res_nxt.ready_res = 1'b0;
          res_nxt.slot      = slot_of(sel_idx);
          pend_nxt          = 1'b1;
          pend_slot_nxt     = sel_idx;
          state_nxt         = wrap ? S_HALVE : S_WRITE;
        end
      end

      S_HALVE: begin
        if (p_vld_r) begin
          wr_en       = 1'b1;
          wr_data.age = {1'b0, e.age[7:1]};
          if (last) begin
            state_nxt = S_WRITE;
          end
        end
      end

      S_WRITE: begin
        wr_en         = 1'b1;
        wr_addr       = tgt_r;
        wr_data       = wdata_r;
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_r;
        state_nxt     = S_IDLE;
      end

      S_CLR: begin
        if (p_vld_r) begin
          wr_en        = 1'b1;
          wr_data.pins = e.pins & ~req_r.clear_mask;
          if (last) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.status    = gtc_pkg::ST_ACK;
            out_data_nxt.ready_res = 1'b1;
            out_data_nxt.slot      = '0;
            state_nxt              = S_IDLE;
          end
        end
      end

      S_DRD: begin
        state_nxt = S_DWR;
      end

      S_DWR: begin
        wr_en                  = 1'b1;
        wr_addr                = tgt_r;
        wr_data.st             = req_r.load_ok ? gtc_pkg::ES_LOADED : gtc_pkg::ES_FAILED;
        pend_nxt               = 1'b0;
        out_valid_nxt          = 1'b1;
        out_data_nxt.status    = gtc_pkg::ST_ACK;
        out_data_nxt.ready_res = req_r.load_ok;
        out_data_nxt.slot      = req_r.done_slot;
        state_nxt              = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      p_vld_r     <= 1'b0;
      age_clk_r   <= '0;
      pend_r      <= 1'b0;
      pend_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      p_vld_r     <= p_vld_nxt;
      age_clk_r   <= age_clk_nxt;
      pend_r      <= pend_nxt;
      pend_slot_r <= pend_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r      <= p_idx_nxt;
    out_data_r   <= out_data_nxt;
    req_r        <= req_nxt;
    tgt_r        <= tgt_nxt;
    wdata_r      <= wdata_nxt;
    res_r        <= res_nxt;
    found_r      <= found_nxt;
    found_idx_r  <= found_idx_nxt;
    found_st_r   <= found_st_nxt;
    found_pins_r <= found_pins_nxt;
    emp_r        <= emp_nxt;
    emp_idx_r    <= emp_idx_nxt;
    vic_r        <= vic_nxt;
    vic_idx_r    <= vic_idx_nxt;
    vic_age_r    <= vic_age_nxt;
  end

endmodule

`default_nettype wire
